/* sv/spf_pkg.sv */
// Shared types, constants and byte/CRC helpers for the servo position packet framer.
// No dependencies; imported by every module of the block.
package spf_pkg;

  localparam int unsigned PktLen    = 16;
  localparam int unsigned CrcStages = 10;  // one stage per CRC byte after the fixed header

  localparam logic [15:0] CrcPoly = 16'h8005;

  localparam logic [3:0] IdxId     = 4'd4;
  localparam logic [3:0] IdxPosLo  = 4'd10;
  localparam logic [3:0] IdxPosHi  = 4'd11;
  localparam logic [3:0] IdxCrcLo  = 4'd14;
  localparam logic [3:0] IdxCrcHi  = 4'd15;
  localparam logic [3:0] IdxLast   = 4'd15;

  // Fixed packet bytes; slots filled at run time hold zero here.
  localparam logic [7:0] FixedBytes [PktLen] = '{
    8'hFF, 8'hFF, 8'hFD, 8'h00,
    8'h00, 8'h09, 8'h00, 8'h03,
    8'h74, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic        vld;
    logic [7:0]  id;
    logic [11:0] pos;
    logic [15:0] crc;
  } pkt_t;

  // One byte of CRC-16, MSB first.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the four header bytes, folded at elaboration.
  localparam logic [15:0] CrcHdr =
    crc_step(crc_step(crc_step(crc_step(16'h0000, 8'hFF), 8'hFF), 8'hFD), 8'h00);

  function automatic logic [7:0] pkt_byte(logic [3:0] idx, logic [7:0] id,
                                          logic [11:0] pos, logic [15:0] crc);
    logic [7:0] b;
    case (idx)
      IdxId:    b = id;
      IdxPosLo: b = pos[7:0];
      IdxPosHi: b = {4'h0, pos[11:8]};
      IdxCrcLo: b = crc[7:0];
      IdxCrcHi: b = crc[15:8];
      default:  b = FixedBytes[idx];
    endcase
    return b;
  endfunction

endpackage

/* sv/spf_crc_pipe.sv */
// CRC pipeline: one register stage per packet byte from the servo id to the last byte before the CRC.
// Depends on spf_pkg.
module spf_crc_pipe (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_vld_i,
  input  logic [7:0]    id_i,
  input  logic [11:0]   pos_i,
  output spf_pkg::pkt_t pkt_o
);
  import spf_pkg::*;

  logic        vld_q [CrcStages];
  logic [7:0]  id_q  [CrcStages];
  logic [11:0] pos_q [CrcStages];
  logic [15:0] crc_q [CrcStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CrcStages; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_vld_i;
      for (int k = 1; k < CrcStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0 folds in the servo id on top of the fixed header.
  always_ff @(posedge clk_i) begin
    id_q[0]  <= id_i;
    pos_q[0] <= pos_i;
    crc_q[0] <= crc_step(CrcHdr, id_i);
  end

  // Stage k adds packet byte IdxId + k.
  for (genvar k = 1; k < CrcStages; k++) begin : g_stage
    localparam logic [3:0] ByteIdx = 4'(int'(IdxId) + k);
    always_ff @(posedge clk_i) begin
      id_q[k]  <= id_q[k-1];
      pos_q[k] <= pos_q[k-1];
      crc_q[k] <= crc_step(crc_q[k-1], pkt_byte(ByteIdx, id_q[k-1], pos_q[k-1], 16'h0000));
    end
  end

  assign pkt_o.vld = vld_q[CrcStages-1];
  assign pkt_o.id  = id_q[CrcStages-1];
  assign pkt_o.pos = pos_q[CrcStages-1];
  assign pkt_o.crc = crc_q[CrcStages-1];

endmodule

/* sv/spf_serializer.sv */
// Packet serializer: one pending packet slot and a byte counter driving registered outputs.
// Depends on spf_pkg.
module spf_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spf_pkg::pkt_t pkt_i,
  output logic          load_o,
  output logic          tx_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_byte_o
);
  import spf_pkg::*;

  logic        pend_vld_q, pend_vld_d;
  pkt_t        pend_q;
  pkt_t        cur_q;
  logic        active_q, active_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        tx_valid_q;
  logic [7:0]  tx_byte_q;
  logic        last_q;
  logic        at_end;
  logic        load;

  assign at_end = active_q && (cnt_q == IdxLast);
  assign load   = pend_vld_q && (!active_q || at_end);

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (pkt_i.vld) begin
      pend_vld_d = 1'b1;
    end else if (load) begin
      pend_vld_d = 1'b0;
    end
    active_d = active_q;
    cnt_d    = cnt_q;
    if (load) begin
      active_d = 1'b1;
      cnt_d    = 4'd0;
    end else if (at_end) begin
      active_d = 1'b0;
    end else if (active_q) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      active_q   <= 1'b0;
      cnt_q      <= 4'd0;
      tx_valid_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      active_q   <= active_d;
      cnt_q      <= cnt_d;
      tx_valid_q <= active_q;
      last_q     <= at_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.vld) begin
      pend_q <= pkt_i;
    end
    if (load) begin
      cur_q <= pend_q;
    end
    tx_byte_q <= pkt_byte(cnt_q, cur_q.id, cur_q.pos, cur_q.crc);
  end

  assign load_o      = load;
  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

endmodule

/* sv/servo_position_packet_framer_core.sv */
// Top level of the servo position packet framer: config register, admission and submodules.
// Depends on spf_pkg, spf_crc_pipe and spf_serializer.

// Each goal position accepted (start_i high while busy_o low) becomes one 16-byte servo
// write packet: FF FF FD 00, servo id, 09 00, 03, 74 00, position low/high, 00 00, then
// the CRC-16 (poly 0x8005, MSB first, zero init) over the first 14 bytes, low byte first.
// Bytes leave one word per cycle on tx_byte_o, each marked by tx_valid_o for exactly one
// cycle; last_byte_o flags the CRC high byte. The receiver cannot stall the stream, so
// every word must be taken in the cycle it is shown. Between the edge that accepts a start
// and the first byte shown lie the CRC stages, the pending slot, the current-packet register
// and the output register. Sustained throughput is set by the one-byte-per-cycle output;
// packets follow each other with no gap. The CRC runs in a 10-stage pipeline, one byte per
// stage, and a pending slot holds the finished packet while the previous one drains, so
// busy_o drops as soon as a packet begins to shift out and the next position can be taken
// long before the current packet is finished.
// Write servo_id only while no packet is in flight; reset value of servo_id is 1.
// A 12-bit position never exceeds 4095, so the saturation is inherent in the port width.
module servo_position_packet_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        start_i,
  input  logic [11:0] goal_position_i,
  output logic        busy_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);
  import spf_pkg::*;

  logic [7:0] servo_id_q;
  logic       inflight_q, inflight_d;
  logic       accept;
  logic       ser_load;
  pkt_t       pipe_pkt;

  // Servo id register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_id_q <= 8'd1;
    end else if (cfg_we_i) begin
      servo_id_q <= cfg_wdata_i;
    end
  end

  // Admit one packet between accept and the moment the serializer loads it; the pipeline
  // never stalls, so this alone keeps the pending slot from overflowing.
  assign accept = start_i && !inflight_q;

  always_comb begin
    inflight_d = inflight_q;
    if (accept) begin
      inflight_d = 1'b1;
    end else if (ser_load) begin
      inflight_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  assign busy_o = inflight_q;

  spf_crc_pipe u_crc_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (accept),
    .id_i     (servo_id_q),
    .pos_i    (goal_position_i),
    .pkt_o    (pipe_pkt)
  );

  spf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pipe_pkt),
    .load_o      (ser_load),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

`ifndef SYNTHESIS
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> tx_valid_o)
    else $error("last_byte_o without tx_valid_o");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o not raised after accept");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_pkt.vld |-> inflight_q)
    else $error("packet left the CRC pipeline without an admitted item");

  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |=> !last_byte_o)
    else $error("two last bytes in a row");
`endif

endmodule
